>>> hdl/cfa_pkg.sv
`default_nettype none
package cfa_pkg;
  localparam logic [7:0] FREE_MARK = 8'h2E;
  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_COMPACT = 2'd2;
  localparam logic [1:0] ACT_READ = 2'd3;
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;
  localparam logic [1:0] POL_UNKNOWN = 2'd3;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_POLICY = 2'd2;
  localparam logic [1:0] ST_SIZE = 2'd3;

  // one segment table entry
  typedef struct packed {
    logic [7:0] owner;
    logic [9:0] first;
    logic [9:0] last;
  } seg_t;
endpackage
`default_nettype wire

>>> hdl/contiguous_fit_allocator_core.sv
`default_nettype none
// Contiguous fit allocator over MEM_UNITS cells. The cell owners and the segment table
// (sorted by start) live in two synchronous memories with registered reads; the
// hole list is never stored, it is recomputed by walking the segment memory. After reset
// the cell store is swept to free with in_tready low. Allocate walks once to search,
// moves each segment above the new one up one entry, fills one cell a cycle and
// walks again to rebuild the hole count and largest hole; release walks once, clearing
// the freed cells one a cycle, then rebuilds; compact walks once, rewriting every cell
// once, then rebuilds. A read passes through S_RD and S_RD2 to S_OUT; a refused
// allocate goes straight to S_OUT. The result waits in an output register, so the
// next beat is taken while it waits; that beat's result then waits until the register
// frees.
module contiguous_fit_allocator_core #(
  parameter int MEM_UNITS = 64
) (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_tvalid,
  output logic in_tready,
  // action[1:0], owner[9:2], request_size[17:10], fit_policy[19:18], cell_address[25:20]
  input  wire  [31:0] in_tdata,
  output logic out_tvalid,
  input  wire  out_tready,
  // status[1:0], placed_start[7:2], cell_owner[15:8], largest_free[22:16],
  // free_hole_count[28:23], segment_count[35:29]
  output logic [39:0] out_tdata
);
  import cfa_pkg::*;
  localparam int AW = (MEM_UNITS > 1) ? $clog2(MEM_UNITS) : 1;
  localparam int CW = $clog2(MEM_UNITS + 1);
  localparam int XW = CW + 1;
  localparam logic [XW-1:0] MU = XW'(MEM_UNITS);

  typedef enum logic [11:0] {
    S_IDLE  = 12'h001, S_SRCH  = 12'h002, S_SHIFT = 12'h004, S_FILL = 12'h008,
    S_REL   = 12'h010, S_CLR   = 12'h020, S_CMP  = 12'h040, S_CFIL = 12'h080,
    S_HOLE  = 12'h100, S_RD    = 12'h200, S_RD2  = 12'h400, S_OUT  = 12'h800
  } state_t;
  state_t state_r;

  // memories
  logic [7:0] cell_mem [MEM_UNITS];
  seg_t seg_mem [MEM_UNITS];
  logic cell_we; logic [AW-1:0] cell_wa; logic [7:0] cell_wd; logic [AW-1:0] cell_ra;
  logic [7:0] cell_rd_r;
  logic seg_we; logic [AW-1:0] seg_wa; seg_t seg_wd; logic [AW-1:0] seg_ra;
  seg_t seg_rd_r;
  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_wa] <= cell_wd;
    cell_rd_r <= cell_mem[cell_ra];
    if (seg_we) seg_mem[seg_wa] <= seg_wd;
    seg_rd_r <= seg_mem[seg_ra];
  end

  // clear sweep of cell store after reset
  logic init_r; logic [CW-1:0] init_cnt_r;

  logic [1:0] pol_r; logic [7:0] own_r, size_r; logic [5:0] addr_r;
  logic [CW-1:0] segn_r, holen_r, big_r;
  logic [CW-1:0] i_r, wr_r;          // segment walk index / write index
  logic rv_r;                        // read data valid for entry i_r-1
  logic [XW-1:0] next_r;             // next free cell during walk
  logic [CW-1:0] hc_r, hb_r;         // hole count / biggest in rebuild
  logic pick_v_r; logic [XW-1:0] pick_r, pick_sz_r;
  logic pos_v_r;                     // read of entry below i_r issued
  logic [XW-1:0] c_r, c_end_r;       // cell fill pointer
  logic [7:0] fill_own_r;
  logic tail_r;                      // compaction is clearing the tail
  logic [1:0] st_r; logic [5:0] placed_r; logic [7:0] rown_r;

  // combinational helpers for the entry read last cycle
  logic [XW-1:0] sf, sl, gap, span, cmp_last, new_last, pick_now;
  seg_t cmp_seg, new_seg;
  assign sf = XW'(seg_rd_r.first);
  assign sl = XW'(seg_rd_r.last);
  assign gap = sf - next_r;
  assign span = sl - sf;
  assign cmp_last = next_r + span;
  assign new_last = pick_r + XW'(size_r) - XW'(1);
  assign cmp_seg = {seg_rd_r.owner, 10'(next_r), 10'(cmp_last)};
  assign new_seg = {own_r, 10'(pick_r), 10'(new_last)};

  // hole seen in this search cycle and whether the policy takes it
  logic hv, take; logic [XW-1:0] hs;
  always_comb begin
    hv = 1'b0; hs = gap;
    if (rv_r) begin
      hv = sf > next_r;
    end else if (i_r == segn_r) begin
      hv = next_r < MU; hs = MU - next_r;
    end
    take = hv && (hs >= XW'(size_r)) &&
           (!pick_v_r || (pol_r == POL_BEST && hs < pick_sz_r)) &&
           (pol_r != POL_WORST || hs == XW'(big_r));
  end
  assign pick_now = take ? next_r : pick_r;

  assign in_tready = (state_r == S_IDLE) && !init_r;

  // memory port control
  always_comb begin
    cell_we = 1'b0; cell_wa = '0; cell_wd = FREE_MARK; cell_ra = AW'(addr_r);
    seg_we = 1'b0; seg_wa = '0; seg_wd = seg_rd_r; seg_ra = i_r[AW-1:0];
    if (init_r) begin
      cell_we = 1'b1; cell_wa = init_cnt_r[AW-1:0];
    end else begin
      case (state_r)
        S_FILL, S_CLR, S_CFIL: begin
          cell_we = 1'b1; cell_wa = c_r[AW-1:0]; cell_wd = fill_own_r;
        end
        S_SHIFT: begin
          seg_ra = i_r[AW-1:0] - AW'(1);
          if (i_r == '0) begin
            seg_we = 1'b1; seg_wa = '0; seg_wd = new_seg;
          end else if (pos_v_r) begin
            seg_we = 1'b1; seg_wa = i_r[AW-1:0];
            seg_wd = (sf > pick_r) ? seg_rd_r : new_seg;
          end
        end
        S_REL: begin
          if (rv_r && seg_rd_r.owner != own_r) begin
            seg_we = 1'b1; seg_wa = wr_r[AW-1:0]; seg_wd = seg_rd_r;
          end
        end
        S_CMP: begin
          if (rv_r) begin
            seg_we = 1'b1; seg_wa = i_r[AW-1:0] - AW'(1); seg_wd = cmp_seg;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; init_r <= 1'b1; init_cnt_r <= '0; out_tvalid <= 1'b0;
      segn_r <= '0; holen_r <= CW'(1); big_r <= CW'(MEM_UNITS); tail_r <= 1'b0;
    end else begin
      if (init_r) begin
        init_cnt_r <= init_cnt_r + CW'(1);
        if (init_cnt_r == CW'(MEM_UNITS - 1)) init_r <= 1'b0;
      end
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          own_r <= in_tdata[9:2]; size_r <= in_tdata[17:10];
          pol_r <= in_tdata[19:18]; addr_r <= in_tdata[25:20];
          st_r <= ST_OK; placed_r <= '0; rown_r <= '0;
          i_r <= '0; wr_r <= '0; rv_r <= 1'b0; next_r <= '0;
          pick_v_r <= 1'b0; pick_sz_r <= '0; pick_r <= '0; tail_r <= 1'b0;
          case (in_tdata[1:0])
            ACT_ALLOC: begin
              if (in_tdata[17:10] == 8'd0) begin
                st_r <= ST_SIZE; state_r <= S_OUT;
              end else if (int'(in_tdata[17:10]) > int'(big_r)) begin
                st_r <= ST_NOMEM; state_r <= S_OUT;
              end else if (in_tdata[19:18] == POL_UNKNOWN) begin
                st_r <= ST_POLICY; state_r <= S_OUT;
              end else state_r <= S_SRCH;
            end
            ACT_RELEASE: state_r <= S_REL;
            ACT_COMPACT: state_r <= S_CMP;
            default: state_r <= S_RD;
          endcase
        end
        // walk segments, evaluating the hole before each one and the tail hole
        S_SRCH: begin
          if (rv_r) begin
            rv_r <= 1'b0; next_r <= sl + XW'(1);
            if (take) begin
              pick_v_r <= 1'b1; pick_r <= next_r; pick_sz_r <= hs;
            end
          end else if (i_r < segn_r) begin
            i_r <= i_r + CW'(1); rv_r <= 1'b1;
          end else if (!pick_v_r && !take) begin
            st_r <= ST_NOMEM; state_r <= S_OUT;
          end else begin
            pick_r <= pick_now; placed_r <= 6'(pick_now);
            if (segn_r >= CW'(MEM_UNITS)) begin
              state_r <= S_OUT;
            end else begin
              i_r <= segn_r; pos_v_r <= 1'b0; state_r <= S_SHIFT;
            end
          end
        end
        // shift entries up from the top until insertion point found
        S_SHIFT: begin
          if (i_r != '0 && !pos_v_r) begin
            pos_v_r <= 1'b1;
          end else if (i_r != '0 && sf > pick_r) begin
            i_r <= i_r - CW'(1); pos_v_r <= 1'b0;
          end else begin
            segn_r <= segn_r + CW'(1);
            c_r <= pick_r; c_end_r <= new_last; fill_own_r <= own_r;
            state_r <= S_FILL;
          end
        end
        S_FILL, S_CLR, S_CFIL: begin
          if (c_r < c_end_r) begin
            c_r <= c_r + XW'(1);
          end else if (state_r == S_CLR) begin
            state_r <= S_REL;
          end else if (state_r == S_CFIL && !tail_r) begin
            state_r <= S_CMP;
          end else begin
            tail_r <= 1'b0;
            i_r <= '0; rv_r <= 1'b0; next_r <= '0; hc_r <= '0; hb_r <= '0;
            state_r <= S_HOLE;
          end
        end
        // compaction: relocate entries one by one and fill their cells
        S_CMP: begin
          if (rv_r) begin
            rv_r <= 1'b0;
            c_r <= next_r; c_end_r <= cmp_last; fill_own_r <= seg_rd_r.owner;
            next_r <= cmp_last + XW'(1);
            state_r <= S_CFIL;
          end else if (i_r < segn_r) begin
            i_r <= i_r + CW'(1); rv_r <= 1'b1;
          end else if (next_r < MU) begin
            c_r <= next_r; c_end_r <= MU - XW'(1); fill_own_r <= FREE_MARK;
            tail_r <= 1'b1; state_r <= S_CFIL;
          end else begin
            i_r <= '0; next_r <= '0; hc_r <= '0; hb_r <= '0; state_r <= S_HOLE;
          end
        end
        // release: compact table in place, clear cells of matching owner
        S_REL: begin
          if (rv_r) begin
            rv_r <= 1'b0;
            if (seg_rd_r.owner == own_r) begin
              c_r <= sf; c_end_r <= sl; fill_own_r <= FREE_MARK; state_r <= S_CLR;
            end else begin
              wr_r <= wr_r + CW'(1);
            end
          end else if (i_r < segn_r) begin
            i_r <= i_r + CW'(1); rv_r <= 1'b1;
          end else begin
            segn_r <= wr_r; i_r <= '0; next_r <= '0; hc_r <= '0; hb_r <= '0;
            state_r <= S_HOLE;
          end
        end
        // rebuild hole count and largest hole
        S_HOLE: begin
          if (rv_r) begin
            rv_r <= 1'b0;
            if (sf > next_r) begin
              hc_r <= hc_r + CW'(1);
              if (gap > XW'(hb_r)) hb_r <= CW'(gap);
            end
            next_r <= sl + XW'(1);
          end else if (i_r < segn_r) begin
            i_r <= i_r + CW'(1); rv_r <= 1'b1;
          end else begin
            if (next_r < MU) begin
              holen_r <= hc_r + CW'(1);
              big_r <= (MU - next_r > XW'(hb_r)) ? CW'(MU - next_r) : hb_r;
            end else begin
              holen_r <= hc_r; big_r <= hb_r;
            end
            state_r <= S_OUT;
          end
        end
        S_RD: state_r <= S_RD2;
        S_RD2: begin
          rown_r <= (int'(addr_r) < MEM_UNITS) ? cell_rd_r : FREE_MARK;
          state_r <= S_OUT;
        end
        S_OUT: if (!out_tvalid) begin
          out_tvalid <= 1'b1;
          out_tdata <= {4'd0, 7'(segn_r), 6'(holen_r), 7'(big_r), rown_r, placed_r, st_r};
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> sim/contiguous_fit_allocator_core_test.sv
`default_nettype none
module contiguous_fit_allocator_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cfa_pkg::*;

  localparam int CELLS = 64;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [31:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [39:0] out_tdata;

  // one expected result beat
  typedef struct {
    logic [1:0] status;
    logic [5:0] start;
    logic [7:0] owner;
    logic [6:0] largest;
    logic [5:0] holes;
    logic [6:0] segs;
  } alloc_result_t;

  // allocator mirror plus queue of pending results
  class alloc_scoreboard;
    logic [7:0] cells[CELLS];
    logic [7:0] seg_own[CELLS];
    int seg_lo[CELLS];
    int seg_hi[CELLS];
    int nseg;
    int hole_lo[CELLS];
    int hole_hi[CELLS];
    int nhole;
    int big;
    alloc_result_t pending[$];
    int errors;

    function new();
      foreach (cells[i]) cells[i] = FREE_MARK;
      nseg = 0;
      nhole = 1;
      hole_lo[0] = 0;
      hole_hi[0] = CELLS - 1;
      big = CELLS;
      errors = 0;
    endfunction

    function void rebuild_holes();
      int next;
      next = 0;
      nhole = 0;
      big = 0;
      for (int i = 0; i < nseg; i++) begin
        if (seg_lo[i] > next) begin
          hole_lo[nhole] = next;
          hole_hi[nhole] = seg_lo[i] - 1;
          if (seg_lo[i] - next > big) big = seg_lo[i] - next;
          nhole++;
        end
        next = seg_hi[i] + 1;
      end
      if (next < CELLS) begin
        hole_lo[nhole] = next;
        hole_hi[nhole] = CELLS - 1;
        if (CELLS - next > big) big = CELLS - next;
        nhole++;
      end
    endfunction

    function void place(logic [7:0] who, int lo, int size);
      int pos;
      if (nseg >= CELLS) return;
      for (int c = lo; c < lo + size && c < CELLS; c++) cells[c] = who;
      pos = 0;
      while (pos < nseg && seg_lo[pos] <= lo) pos++;
      for (int j = nseg; j > pos; j--) begin
        seg_own[j] = seg_own[j-1];
        seg_lo[j] = seg_lo[j-1];
        seg_hi[j] = seg_hi[j-1];
      end
      seg_own[pos] = who;
      seg_lo[pos] = lo;
      seg_hi[pos] = lo + size - 1;
      nseg++;
      rebuild_holes();
    endfunction

    // work out the result of one accepted command beat
    function void note(logic [31:0] d);
      alloc_result_t r;
      logic [1:0] act;
      logic [7:0] who;
      int size;
      logic [1:0] pol;
      int addr;
      int pick;
      int pick_size;
      int hs;
      int wr;
      int next;
      int span;
      act = d[1:0];
      who = d[9:2];
      size = int'(d[17:10]);
      pol = d[19:18];
      addr = int'(d[25:20]);
      r.status = ST_OK;
      r.start = '0;
      r.owner = '0;
      case (act)
        ACT_ALLOC: begin
          if (size == 0) r.status = ST_SIZE;
          else if (size > big) r.status = ST_NOMEM;
          else if (pol == POL_UNKNOWN) r.status = ST_POLICY;
          else begin
            pick = nhole;
            pick_size = 0;
            for (int i = 0; i < nhole; i++) begin
              hs = hole_hi[i] - hole_lo[i] + 1;
              if (hs < size) continue;
              if (pol == POL_FIRST || (pol == POL_WORST && hs == big)) begin
                pick = i;
                break;
              end
              if (pol == POL_BEST && (pick == nhole || hs < pick_size)) begin
                pick = i;
                pick_size = hs;
              end
            end
            if (pick < nhole) begin
              r.start = 6'(hole_lo[pick]);
              place(who, hole_lo[pick], size);
            end else r.status = ST_NOMEM;
          end
        end
        ACT_RELEASE: begin
          wr = 0;
          for (int i = 0; i < nseg; i++) begin
            if (seg_own[i] == who) begin
              for (int c = seg_lo[i]; c <= seg_hi[i]; c++) cells[c] = FREE_MARK;
            end else begin
              seg_own[wr] = seg_own[i];
              seg_lo[wr] = seg_lo[i];
              seg_hi[wr] = seg_hi[i];
              wr++;
            end
          end
          nseg = wr;
          rebuild_holes();
        end
        ACT_COMPACT: begin
          next = 0;
          foreach (cells[c]) cells[c] = FREE_MARK;
          for (int i = 0; i < nseg; i++) begin
            span = seg_hi[i] - seg_lo[i];
            seg_lo[i] = next;
            seg_hi[i] = next + span;
            for (int c = seg_lo[i]; c <= seg_hi[i]; c++) cells[c] = seg_own[i];
            next = seg_hi[i] + 1;
          end
          rebuild_holes();
        end
        default: r.owner = (addr < CELLS) ? cells[addr] : FREE_MARK;
      endcase
      r.largest = 7'(big);
      r.holes = 6'(nhole);
      r.segs = 7'(nseg);
      pending.push_back(r);
    endfunction

    // compare one result beat with the oldest expectation
    function void check(logic [39:0] d);
      alloc_result_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[1:0] !== e.status) begin
        $error("status expected %0d actual %0d", e.status, d[1:0]); errors++;
      end
      if (d[7:2] !== e.start) begin
        $error("placed_start expected %0d actual %0d", e.start, d[7:2]); errors++;
      end
      if (d[15:8] !== e.owner) begin
        $error("cell_owner expected %h actual %h", e.owner, d[15:8]); errors++;
      end
      if (d[22:16] !== e.largest) begin
        $error("largest_free expected %0d actual %0d", e.largest, d[22:16]); errors++;
      end
      if (d[28:23] !== e.holes) begin
        $error("free_hole_count expected %0d actual %0d", e.holes, d[28:23]); errors++;
      end
      if (d[35:29] !== e.segs) begin
        $error("segment_count expected %0d actual %0d", e.segs, d[35:29]); errors++;
      end
    endfunction
  endclass

  alloc_scoreboard sb;
  int sent;
  bit quiet;
  bit held;
  longint cycles;

  contiguous_fit_allocator_core #(.MEM_UNITS(CELLS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  // clock
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // cycle limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("contiguous_fit_allocator_core test failed");
        $finish;
      end
    end
  end

  // result side: random stalls and one long hold-off
  initial begin
    out_tready = 1'b0;
    held = 1'b0;
    repeat (12) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!held && sent >= 300) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (3000) @(posedge clk);
      end else if (!quiet && (sent / 64) % 3 != 2 && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check(out_tdata);
  end

  // one command beat, then maybe a gap
  task automatic send_cmd(logic [1:0] act, logic [7:0] who, logic [7:0] size,
                          logic [1:0] pol, logic [5:0] addr);
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, addr, pol, size, who, act};
    do @(posedge clk); while (!in_tready);
    sb.note(in_tdata);
    sent++;
    if (!quiet && (sent / 50) % 3 != 1 && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] pick_owner();
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return 8'("A" + $urandom_range(0, 7));
  endfunction

  initial begin
    logic [7:0] size;
    int r;
    sb = new();
    sent = 0;
    quiet = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every action, each policy and the corner cases
    send_cmd(ACT_ALLOC, "A", 8'd10, POL_FIRST, 6'd0);
    send_cmd(ACT_ALLOC, "B", 8'd5, POL_FIRST, 6'd0);
    send_cmd(ACT_ALLOC, "C", 8'd20, POL_BEST, 6'd0);
    send_cmd(ACT_ALLOC, FREE_MARK, 8'd3, POL_WORST, 6'd0);
    send_cmd(ACT_ALLOC, 8'hFF, 8'd4, POL_FIRST, 6'd0);
    send_cmd(ACT_READ, 8'h00, 8'd0, POL_FIRST, 6'd0);
    send_cmd(ACT_READ, 8'hFF, 8'hFF, POL_UNKNOWN, 6'd63);
    send_cmd(ACT_READ, 8'h00, 8'd0, POL_FIRST, 6'd36);
    send_cmd(ACT_RELEASE, "B", 8'd0, POL_FIRST, 6'd0);
    send_cmd(ACT_RELEASE, 8'h00, 8'd0, POL_FIRST, 6'd0);
    send_cmd(ACT_ALLOC, "D", 8'd2, POL_BEST, 6'd0);
    send_cmd(ACT_ALLOC, "E", 8'd3, POL_WORST, 6'd0);
    send_cmd(ACT_COMPACT, 8'h00, 8'd0, POL_FIRST, 6'd0);
    send_cmd(ACT_ALLOC, "F", 8'd0, POL_FIRST, 6'd0);
    send_cmd(ACT_ALLOC, "F", 8'd255, POL_FIRST, 6'd0);
    send_cmd(ACT_ALLOC, "F", 8'd1, POL_UNKNOWN, 6'd0);
    send_cmd(ACT_ALLOC, "G", 8'(sb.big), POL_FIRST, 6'd0);
    send_cmd(ACT_ALLOC, "G", 8'd1, POL_BEST, 6'd0);
    send_cmd(ACT_READ, 8'h00, 8'd0, POL_FIRST, 6'd40);
    send_cmd(ACT_RELEASE, FREE_MARK, 8'd0, POL_FIRST, 6'd0);
    send_cmd(ACT_RELEASE, "G", 8'd0, POL_FIRST, 6'd0);
    send_cmd(ACT_RELEASE, "A", 8'd0, POL_FIRST, 6'd0);
    send_cmd(ACT_RELEASE, "C", 8'd0, POL_FIRST, 6'd0);
    send_cmd(ACT_ALLOC, "H", 8'd64, POL_WORST, 6'd0);

    // random commands, about half of them allocations, mostly of small sizes
    for (int n = 0; n < 900; n++) begin
      if (n >= 800) quiet = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 50) begin
        case ($urandom_range(0, 19))
          0: size = 8'd0;
          1: size = 8'($urandom);
          2, 3: size = 8'($urandom_range(13, 64));
          default: size = 8'($urandom_range(1, 12));
        endcase
        send_cmd(ACT_ALLOC, pick_owner(), size,
                 ($urandom_range(0, 9) == 0) ? POL_UNKNOWN : 2'($urandom_range(0, 2)),
                 6'($urandom));
      end else if (r < 65) begin
        send_cmd(ACT_RELEASE, pick_owner(), 8'($urandom), 2'($urandom), 6'($urandom));
      end else if (r < 70) begin
        send_cmd(ACT_COMPACT, 8'($urandom), 8'($urandom), 2'($urandom), 6'($urandom));
      end else begin
        send_cmd(ACT_READ, 8'($urandom), 8'($urandom), 2'($urandom), 6'($urandom));
      end
    end
    in_tvalid <= 1'b0;

    // drain
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (sb.errors == 0) begin
      $display("contiguous_fit_allocator_core test passed");
    end else begin
      $display("contiguous_fit_allocator_core test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
